// ----- sv/maze_backtracker_walk_defines.svh -----
// Assertion macros shared by the maze walk RTL.
`ifndef MAZE_BACKTRACKER_WALK_DEFINES_SVH
`define MAZE_BACKTRACKER_WALK_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define MBW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("maze walk assertion failed");
// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define MBW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("maze walk assertion failed");
`else
`define MBW_ASSERT_IMPL(label, ante, cons)
`define MBW_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- sv/mbw_pkg.sv -----
// Shared constants, types and helper functions of the maze walk block.
`default_nettype none

package mbw_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
    localparam int CELL_AW     = $clog2(CELLS);
    localparam int DEPTH_W     = CELL_AW + 1;
    localparam int DIM_W       = 7;
    localparam int CELL_W      = 5;
    localparam int PASS_W      = 4;
    localparam int VISITED_BIT = 4;
    localparam int CFG_IDX_W   = 1;

    // The divider retires two quotient bits per cycle.
    localparam int DIV_STEPS   = (CELL_AW + 1) / 2;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [CELL_W-1:0] VISITED_MASK = CELL_W'(1) << VISITED_BIT;
    localparam logic [DIM_W-1:0]  COL_LIMIT    = DIM_W'(MAX_COLUMNS);
    localparam logic [DIM_W-1:0]  ROW_LIMIT    = DIM_W'(MAX_ROWS);

    // Operation codes.
    localparam logic [1:0] OP_RESTART = 2'd0;
    localparam logic [1:0] OP_STEP    = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_CARVED      = 3'd0;
    localparam logic [2:0] ST_BACKTRACKED = 3'd1;
    localparam logic [2:0] ST_FINISHED    = 3'd2;
    localparam logic [2:0] ST_CELL_DATA   = 3'd3;
    localparam logic [2:0] ST_RESTARTED   = 3'd4;

    // Directions.
    localparam logic [1:0] DIR_PX = 2'd0;
    localparam logic [1:0] DIR_NY = 2'd1;
    localparam logic [1:0] DIR_NX = 2'd2;
    localparam logic [1:0] DIR_PY = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

    typedef enum logic [3:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_TOP,
        FSM_DIV,
        FSM_PROBE,
        FSM_CHECK,
        FSM_CARVE,
        FSM_READ,
        FSM_EMIT
    } mbw_state_t;

    typedef struct packed {
        logic               done;
        logic [CELL_AW-1:0] quotient;
        logic [DIM_W-1:0]   remainder;
    } div_result_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] v;
        if (r == '0) begin
            v = DIM_W'(1);
        end else if (r > maxv) begin
            v = maxv;
        end else begin
            v = r;
        end
        return v;
    endfunction

    function automatic logic [PASS_W-1:0] dir_mask(input logic [1:0] d);
        return PASS_W'(1) << d;
    endfunction

    function automatic logic [1:0] opposite_dir(input logic [1:0] d);
        return d + 2'd2;
    endfunction

endpackage

`default_nettype wire

// ----- sv/maze_backtracker_walk.sv -----
// Top level of the maze walk block: sequencer around the cell store and walk stack.
// Usage: the block builds a perfect maze by a depth-first walk with an explicit stack.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) for the grid width
// and height; write it only while the block is idle. Items arrive on the input channel
// (in_valid, in_stall, op, random_direction, cell_index) and each restart, step or read
// gives exactly one result on the output channel (out_valid, out_stall and the fields).
// A transfer happens at a rising edge with valid high and stall low.
// Sequence: a read issues its cell store read at the transfer, takes the read data in
// FSM_READ and hands it on through FSM_EMIT. A step reads the stack top, runs the
// divider that splits it into column and row and makes up to four probe reads of the
// cell store, checking each read result. A step with nothing left to do goes straight
// to FSM_EMIT. A restart sweeps the whole cell store, one entry a cycle, then answers.
// One item is in work at a time; in_stall is high from the transfer until the result
// has moved into the output register.
// After reset the block runs a clearing pass over the whole cell store and
// stalls its input meanwhile; configuration writes are taken at any time.
// When the receiver stalls, the result waits in the output register and the block can
// still take and work on one more item, holding that result until the register frees.
`default_nettype none
`include "maze_backtracker_walk_defines.svh"

module maze_backtracker_walk import mbw_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    input  logic [1:0]           random_direction,
    input  logic [CELL_AW-1:0]   cell_index,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [CELL_AW-1:0]   from_cell,
    output logic [CELL_AW-1:0]   to_cell,
    output logic [1:0]           carve_direction,
    output logic [PASS_W-1:0]    passages,
    output logic [CELL_AW-1:0]   cells_left
);

    // Control state.
    mbw_state_t           state_reg;
    mbw_state_t           state_next;
    logic [DIM_W-1:0]     grid_width_reg;
    logic [DIM_W-1:0]     grid_height_reg;
    logic [CELL_AW-1:0]   clr_addr_reg;
    logic                 restart_flag_reg;
    logic [DEPTH_W-1:0]   depth_reg;
    logic [CELL_AW-1:0]   remaining_reg;
    logic [1:0]           k_reg;
    logic                 out_valid_reg;

    // Working payload of the item in hand.
    logic [1:0]           rdir_reg;
    logic [CELL_AW-1:0]   top_reg;
    logic [CELL_W-1:0]    top_cell_reg;
    logic [CELL_AW-1:0]   cand_n_reg;
    logic [1:0]           cand_d_reg;

    // Pending result and output register.
    logic [2:0]           res_status_reg;
    logic [CELL_AW-1:0]   res_from_reg;
    logic [CELL_AW-1:0]   res_to_reg;
    logic [1:0]           res_dir_reg;
    logic [PASS_W-1:0]    res_pass_reg;
    logic [CELL_AW-1:0]   res_left_reg;
    logic [2:0]           out_status_reg;
    logic [CELL_AW-1:0]   out_from_reg;
    logic [CELL_AW-1:0]   out_to_reg;
    logic [1:0]           out_dir_reg;
    logic [PASS_W-1:0]    out_pass_reg;
    logic [CELL_AW-1:0]   out_left_reg;

    // Memory ports.
    logic                 cell_we;
    logic [CELL_AW-1:0]   cell_waddr;
    logic [CELL_W-1:0]    cell_wdata;
    logic                 cell_re;
    logic [CELL_AW-1:0]   cell_raddr;
    logic [CELL_W-1:0]    cell_rdata;
    logic                 stack_we;
    logic [CELL_AW-1:0]   stack_waddr;
    logic [CELL_AW-1:0]   stack_wdata;
    logic                 stack_re;
    logic [CELL_AW-1:0]   stack_raddr;
    logic [CELL_AW-1:0]   stack_rdata;

    logic                 div_start;
    div_result_t          div_res;

    // Derived values.
    logic [DIM_W-1:0]     w_eff;
    logic [DIM_W-1:0]     h_eff;
    logic [2*DIM_W-1:0]   wh_full;
    logic [DEPTH_W-1:0]   grid_cells;
    logic [CELL_AW-1:0]   restart_left;
    logic [DEPTH_W-1:0]   depth_minus1;
    logic                 in_fire;
    logic                 out_free;
    logic                 step_ok;
    logic                 read_in_range;
    logic                 last_k;
    logic                 probe_visited;
    logic                 backtrack;
    logic                 push_ok;

    // Neighbour candidate.
    logic [1:0]           cand_dir;
    logic                 cand_ok;
    logic [CELL_AW-1:0]   cand_n;
    logic [DIM_W:0]       cx_ext;
    logic [DIM_W:0]       w_ext8;
    logic [DEPTH_W-1:0]   cy_ext;
    logic [DEPTH_W-1:0]   h_ext;
    logic [CELL_AW-1:0]   w_ext12;

    assign w_eff        = eff_dim(grid_width_reg, COL_LIMIT);
    assign h_eff        = eff_dim(grid_height_reg, ROW_LIMIT);
    assign wh_full      = w_eff * h_eff;
    assign grid_cells   = wh_full[DEPTH_W-1:0];
    assign restart_left = CELL_AW'(grid_cells - 1'b1);
    assign depth_minus1 = depth_reg - 1'b1;

    assign in_fire       = in_valid && !in_stall;
    assign out_free      = !out_valid_reg || !out_stall;
    assign step_ok       = (remaining_reg != '0) && (depth_reg != '0);
    assign read_in_range = {1'b0, cell_index} < grid_cells;
    assign last_k        = (k_reg == 2'd3);
    assign probe_visited = cell_rdata[VISITED_BIT];
    assign push_ok       = depth_reg < DEPTH_W'(CELLS);
    assign backtrack     = ((state_reg == FSM_PROBE) && !cand_ok && last_k) ||
                           ((state_reg == FSM_CHECK) && probe_visited && last_k);

    // The divider holds the column (remainder) and row (quotient) of the stack
    // top from its end until the next step starts it again.
    assign cand_dir = rdir_reg + k_reg;
    assign cx_ext   = {1'b0, div_res.remainder};
    assign w_ext8   = {1'b0, w_eff};
    assign cy_ext   = {1'b0, div_res.quotient};
    assign h_ext    = DEPTH_W'(h_eff);
    assign w_ext12  = CELL_AW'(w_eff);

    // A stack top outside the current grid can still reach an in-bounds
    // neighbour, so every direction checks the row against the grid height.
    always_comb
    begin
        case (cand_dir)
            DIR_PX:
            begin
                cand_ok = ((cx_ext + 1'b1) < w_ext8) && (cy_ext < h_ext);
                cand_n  = top_reg + 1'b1;
            end
            DIR_NY:
            begin
                cand_ok = (cy_ext != '0) && ((cy_ext - 1'b1) < h_ext);
                cand_n  = top_reg - w_ext12;
            end
            DIR_NX:
            begin
                cand_ok = (cx_ext != '0) && (cy_ext < h_ext);
                cand_n  = top_reg - 1'b1;
            end
            DIR_PY:
            begin
                cand_ok = (cy_ext + 1'b1) < h_ext;
                cand_n  = top_reg + w_ext12;
            end
            default:
            begin
                cand_ok = 1'b0;
                cand_n  = top_reg;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_CLEAR:
            begin
                if (clr_addr_reg == '0)
                begin
                    state_next = restart_flag_reg ? FSM_EMIT : FSM_IDLE;
                end
            end
            FSM_IDLE:
            begin
                if (in_fire)
                begin
                    case (op)
                        OP_RESTART: state_next = FSM_CLEAR;
                        OP_STEP:    state_next = step_ok ? FSM_TOP : FSM_EMIT;
                        OP_READ:    state_next = read_in_range ? FSM_READ : FSM_EMIT;
                        OP_NONE:    state_next = FSM_IDLE;
                        default:    state_next = FSM_IDLE;
                    endcase
                end
            end
            FSM_TOP:
            begin
                state_next = FSM_DIV;
            end
            FSM_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = FSM_PROBE;
                end
            end
            FSM_PROBE:
            begin
                if (cand_ok)
                begin
                    state_next = FSM_CHECK;
                end
                else if (last_k)
                begin
                    state_next = FSM_EMIT;
                end
            end
            FSM_CHECK:
            begin
                if (!probe_visited)
                begin
                    state_next = FSM_CARVE;
                end
                else
                begin
                    state_next = last_k ? FSM_EMIT : FSM_PROBE;
                end
            end
            FSM_CARVE:
            begin
                state_next = FSM_EMIT;
            end
            FSM_READ:
            begin
                state_next = FSM_EMIT;
            end
            FSM_EMIT:
            begin
                if (out_free)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Memory, divider and handshake controls.
    always_comb
    begin
        in_stall    = (state_reg != FSM_IDLE);
        cell_we     = 1'b0;
        cell_waddr  = '0;
        cell_wdata  = '0;
        cell_re     = 1'b0;
        cell_raddr  = '0;
        stack_we    = 1'b0;
        stack_waddr = '0;
        stack_wdata = '0;
        stack_re    = 1'b0;
        stack_raddr = '0;
        div_start   = 1'b0;
        case (state_reg)
            FSM_CLEAR:
            begin
                // The last entry swept is cell 0, which a restart leaves visited.
                cell_we    = 1'b1;
                cell_waddr = clr_addr_reg;
                cell_wdata = ((clr_addr_reg == '0) && restart_flag_reg) ? VISITED_MASK : '0;
            end
            FSM_IDLE:
            begin
                if (in_fire && (op == OP_READ) && read_in_range)
                begin
                    cell_re    = 1'b1;
                    cell_raddr = cell_index;
                end
                if (in_fire && (op == OP_STEP) && step_ok)
                begin
                    stack_re    = 1'b1;
                    stack_raddr = depth_minus1[CELL_AW-1:0];
                end
                if (in_fire && (op == OP_RESTART))
                begin
                    stack_we    = 1'b1;
                    stack_waddr = '0;
                    stack_wdata = '0;
                end
            end
            FSM_TOP:
            begin
                cell_re    = 1'b1;
                cell_raddr = stack_rdata;
                div_start  = 1'b1;
            end
            FSM_PROBE:
            begin
                if (cand_ok)
                begin
                    cell_re    = 1'b1;
                    cell_raddr = cand_n;
                end
            end
            FSM_CHECK:
            begin
                if (!probe_visited)
                begin
                    cell_we    = 1'b1;
                    cell_waddr = cand_n_reg;
                    cell_wdata = cell_rdata | VISITED_MASK |
                                 {1'b0, dir_mask(opposite_dir(cand_d_reg))};
                end
            end
            FSM_CARVE:
            begin
                cell_we    = 1'b1;
                cell_waddr = top_reg;
                cell_wdata = top_cell_reg | {1'b0, dir_mask(cand_d_reg)};
                if (push_ok)
                begin
                    stack_we    = 1'b1;
                    stack_waddr = depth_reg[CELL_AW-1:0];
                    stack_wdata = cand_n_reg;
                end
            end
            default:
            begin
                cell_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= FSM_CLEAR;
            grid_width_reg   <= DIM_W'(64);
            grid_height_reg  <= DIM_W'(32);
            clr_addr_reg     <= '1;
            restart_flag_reg <= 1'b0;
            depth_reg        <= '0;
            remaining_reg    <= '0;
            k_reg            <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WIDTH:  grid_width_reg  <= cfg_data;
                    CFG_HEIGHT: grid_height_reg <= cfg_data;
                    default:    grid_width_reg  <= grid_width_reg;
                endcase
            end

            if ((state_reg == FSM_IDLE) && in_fire && (op == OP_RESTART))
            begin
                clr_addr_reg     <= '1;
                restart_flag_reg <= 1'b1;
                depth_reg        <= DEPTH_W'(1);
                remaining_reg    <= restart_left;
            end
            else if (state_reg == FSM_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg - 1'b1;
            end
            else if (state_reg == FSM_CARVE)
            begin
                if (push_ok)
                begin
                    depth_reg <= depth_reg + 1'b1;
                end
                remaining_reg <= remaining_reg - 1'b1;
            end
            else if (backtrack)
            begin
                depth_reg <= depth_minus1;
            end

            if (state_reg == FSM_TOP)
            begin
                k_reg <= '0;
            end
            else if (((state_reg == FSM_PROBE) && !cand_ok && !last_k) ||
                     ((state_reg == FSM_CHECK) && probe_visited && !last_k))
            begin
                k_reg <= k_reg + 1'b1;
            end

            if ((state_reg == FSM_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and result payload.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            FSM_IDLE:
            begin
                if (in_fire)
                begin
                    rdir_reg       <= random_direction;
                    res_from_reg   <= '0;
                    res_to_reg     <= '0;
                    res_dir_reg    <= '0;
                    res_pass_reg   <= '0;
                    res_left_reg   <= remaining_reg;
                    case (op)
                        OP_RESTART:
                        begin
                            res_status_reg <= ST_RESTARTED;
                            res_left_reg   <= restart_left;
                        end
                        OP_STEP:    res_status_reg <= ST_FINISHED;
                        OP_READ:    res_status_reg <= ST_CELL_DATA;
                        default:    res_status_reg <= ST_FINISHED;
                    endcase
                end
            end
            FSM_TOP:
            begin
                top_reg <= stack_rdata;
            end
            FSM_DIV:
            begin
                // The top cell's read data is stable throughout the division.
                top_cell_reg <= cell_rdata;
            end
            FSM_PROBE:
            begin
                cand_n_reg <= cand_n;
                cand_d_reg <= cand_dir;
            end
            FSM_CARVE:
            begin
                res_status_reg <= ST_CARVED;
                res_from_reg   <= top_reg;
                res_to_reg     <= cand_n_reg;
                res_dir_reg    <= cand_d_reg;
                res_pass_reg   <= top_cell_reg[PASS_W-1:0] | dir_mask(cand_d_reg);
                res_left_reg   <= remaining_reg - 1'b1;
            end
            FSM_READ:
            begin
                res_pass_reg <= cell_rdata[PASS_W-1:0];
            end
            FSM_EMIT:
            begin
                if (out_free)
                begin
                    out_status_reg <= res_status_reg;
                    out_from_reg   <= res_from_reg;
                    out_to_reg     <= res_to_reg;
                    out_dir_reg    <= res_dir_reg;
                    out_pass_reg   <= res_pass_reg;
                    out_left_reg   <= res_left_reg;
                end
            end
            default:
            begin
                rdir_reg <= rdir_reg;
            end
        endcase

        if (backtrack)
        begin
            res_status_reg <= ST_BACKTRACKED;
            res_from_reg   <= top_reg;
            res_to_reg     <= '0;
            res_dir_reg    <= '0;
            res_pass_reg   <= top_cell_reg[PASS_W-1:0];
            res_left_reg   <= remaining_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign from_cell       = out_from_reg;
    assign to_cell         = out_to_reg;
    assign carve_direction = out_dir_reg;
    assign passages        = out_pass_reg;
    assign cells_left      = out_left_reg;

    mbw_ram #(
        .ADDR_W (CELL_AW),
        .DATA_W (CELL_W)
    ) u_cell_store (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .re    (cell_re),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    mbw_ram #(
        .ADDR_W (CELL_AW),
        .DATA_W (CELL_AW)
    ) u_walk_stack (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (stack_re),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    mbw_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (stack_rdata),
        .divisor  (w_eff),
        .result   (div_res)
    );

    // The stack is only read when it holds an entry.
    `MBW_ASSERT_IMPL(a_stack_read_nonempty, stack_re, depth_reg != '0)
    // A carve with room on the stack pushes exactly one entry.
    `MBW_ASSERT_NEXT(a_carve_push, (state_reg == FSM_CARVE) && push_ok, depth_reg == $past(depth_reg) + 1'b1)
    // The neighbour written during the probe is never the stack top itself.
    `MBW_ASSERT_IMPL(a_neighbour_not_top, cell_we && (state_reg == FSM_CHECK), cell_waddr != top_reg)
    // The clearing pass ends once it has swept cell 0.
    `MBW_ASSERT_NEXT(a_clear_ends, (state_reg == FSM_CLEAR) && (clr_addr_reg == '0), state_reg != FSM_CLEAR)

endmodule

`default_nettype wire

// ----- sv/mbw_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module mbw_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/mbw_divider.sv -----
// Radix-4 restoring divider that splits a cell index into row and column.
`default_nettype none

module mbw_divider import mbw_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [CELL_AW-1:0] dividend,
    input  logic [DIM_W-1:0]   divisor,
    output div_result_t        result
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [CELL_AW-1:0]   quo_reg;
    logic [DIM_W-1:0]     rem_reg;
    logic [DIM_W-1:0]     dsr_reg;

    logic [CELL_AW-1:0]   quo_next;
    logic [DIM_W-1:0]     rem_next;
    logic [DIM_W-1:0]     trial;

    // Two dependent compare-and-subtract steps per cycle. The partial
    // remainder stays below the divisor, so its top bit is always clear.
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < 2; i++)
        begin
            trial    = {rem_next[DIM_W-2:0], quo_next[CELL_AW-1]};
            quo_next = {quo_next[CELL_AW-2:0], 1'b0};
            if (trial >= dsr_reg)
            begin
                trial       = trial - dsr_reg;
                quo_next[0] = 1'b1;
            end
            rem_next = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dsr_reg <= divisor;
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign result = '{done: done_reg, quotient: quo_reg, remainder: rem_reg};

endmodule

`default_nettype wire
